/* hdl/usb_control_endpoint_responder_defines.svh */
// Assertion macros used by the checker file.
`ifndef USB_CONTROL_ENDPOINT_RESPONDER_DEFINES_SVH
`define USB_CONTROL_ENDPOINT_RESPONDER_DEFINES_SVH

// Check the consequent in the same cycle as the antecedent.
`define USBCER_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("usbcer check failed");

// Check the consequent in the cycle after the antecedent.
`define USBCER_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("usbcer check failed");

`endif

/* hdl/usbcer_pkg.sv */
`timescale 1ns / 1ps

package usbcer_pkg;

    localparam int MAX_PACKET_DEFAULT  = 64;
    localparam int QUEUE_DEPTH_DEFAULT = 4;
    localparam int STRING_SLOTS        = 4;
    localparam int SIZE_W              = 7;

    localparam logic [15:0] REQ_SET_ADDRESS    = 16'h0500;
    localparam logic [15:0] REQ_SET_CONFIG     = 16'h0900;
    localparam logic [15:0] REQ_GET_DESC_DEV   = 16'h0680;
    localparam logic [15:0] REQ_GET_DESC_IFACE = 16'h0681;

    localparam logic [7:0]  DESC_TYPE_STRING = 8'h03;
    localparam logic [15:0] VAL_DEVICE       = 16'h0100;
    localparam logic [15:0] VAL_CONFIG       = 16'h0200;
    localparam logic [15:0] VAL_REPORT       = 16'h2200;

    localparam logic [7:0]  DEVICE_LEN_RESET = 8'd18;
    localparam logic [9:0]  CONFIG_LEN_RESET = 10'd41;

    typedef enum logic [2:0] {
        EV_SETUP     = 3'd0,
        EV_IN_DONE   = 3'd1,
        EV_OUT       = 3'd2,
        EV_SOF       = 3'd3,
        EV_BUS_RESET = 3'd4
    } event_t;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_ARMED = 2'd1,
        ACT_STALL = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        SEL_DEVICE = 2'd0,
        SEL_CONFIG = 2'd1,
        SEL_REPORT = 2'd2,
        SEL_STRING = 2'd3
    } desc_sel_t;

    typedef enum logic [2:0] {
        CMD_STALL     = 3'd0,
        CMD_STATUS    = 3'd1,
        CMD_DATA      = 3'd2,
        CMD_IN        = 3'd3,
        CMD_BUS_RESET = 3'd4
    } cmd_op_t;

    typedef enum logic [2:0] {
        REG_DEVICE_LEN     = 3'd0,
        REG_CONFIG_LEN     = 3'd1,
        REG_REPORT_LEN     = 3'd2,
        REG_STRING_COUNT   = 3'd3,
        REG_STRING_LENGTHS = 3'd4
    } reg_idx_t;

    typedef enum logic {
        BACK_RUN    = 1'b0,
        BACK_SECOND = 1'b1
    } back_state_t;

    typedef struct packed {
        cmd_op_t     op;
        logic        set_addr;
        logic [6:0]  addr;
        desc_sel_t   sel;
        logic [1:0]  str;
        logic [15:0] len;
    } cmd_t;

    typedef struct packed {
        action_t           action;
        logic [15:0]       offset;
        logic [SIZE_W-1:0] size;
        desc_sel_t         sel;
        logic [1:0]        str;
        logic              toggle;
        logic              odd;
        logic              addr_write;
        logic [6:0]        addr;
        logic              last;
    } result_t;

    typedef struct packed {
        logic [7:0]  device_len;
        logic [9:0]  config_len;
        logic [9:0]  report_len;
        logic [2:0]  string_count;
        logic [31:0] string_lengths;
    } cfg_t;

endpackage

/* hdl/usb_control_endpoint_responder.sv */
`timescale 1ns / 1ps

// Endpoint 0 control responder: takes one bus event per item (setup, IN done, OUT, SOF,
// bus reset) and returns the packets to arm, stall or address writes it causes. The front
// end decodes an item in the cycle it is accepted and places it in a QUEUE_DEPTH-entry
// command queue (four entries by default), so items are taken one per cycle until the
// queue fills. The back end holds the transfer state and loads one result per cycle into
// the output register while the output is not stalled; a setup that needs two packets
// passes through BACK_SECOND before the next item is taken. Descriptor lengths are to be
// set through the APB registers while no item is in flight; the block does not enforce it.
module usb_control_endpoint_responder
#(
    parameter int MAX_PACKET  = usbcer_pkg::MAX_PACKET_DEFAULT,
    parameter int QUEUE_DEPTH = usbcer_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  req_type,
    input  logic [15:0] request_and_type,
    input  logic [15:0] setup_value,
    input  logic [15:0] setup_length,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  action,
    output logic [15:0] packet_offset,
    output logic [6:0]  packet_size,
    output logic [1:0]  descriptor_select,
    output logic [1:0]  string_number,
    output logic        data_toggle,
    output logic        buffer_odd,
    output logic        address_write,
    output logic [6:0]  device_address,
    output logic        last
);

    usbcer_pkg::cfg_t    cfg_reg;
    usbcer_pkg::cfg_t    cfg_next;
    logic                cfg_write;
    logic                push;
    logic                queue_full;
    usbcer_pkg::cmd_t    push_cmd;
    logic                pop;
    logic                pop_valid;
    usbcer_pkg::cmd_t    pop_cmd;
    usbcer_pkg::result_t res;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (paddr[4:2])
                usbcer_pkg::REG_DEVICE_LEN:     cfg_next.device_len     = pwdata[7:0];
                usbcer_pkg::REG_CONFIG_LEN:     cfg_next.config_len     = pwdata[9:0];
                usbcer_pkg::REG_REPORT_LEN:     cfg_next.report_len     = pwdata[9:0];
                usbcer_pkg::REG_STRING_COUNT:   cfg_next.string_count   = pwdata[2:0];
                usbcer_pkg::REG_STRING_LENGTHS: cfg_next.string_lengths = pwdata;
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            usbcer_pkg::REG_DEVICE_LEN:     prdata = {24'b0, cfg_reg.device_len};
            usbcer_pkg::REG_CONFIG_LEN:     prdata = {22'b0, cfg_reg.config_len};
            usbcer_pkg::REG_REPORT_LEN:     prdata = {22'b0, cfg_reg.report_len};
            usbcer_pkg::REG_STRING_COUNT:   prdata = {29'b0, cfg_reg.string_count};
            usbcer_pkg::REG_STRING_LENGTHS: prdata = cfg_reg.string_lengths;
            default:                        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_len     <= usbcer_pkg::DEVICE_LEN_RESET;
            cfg_reg.config_len     <= usbcer_pkg::CONFIG_LEN_RESET;
            cfg_reg.report_len     <= '0;
            cfg_reg.string_count   <= '0;
            cfg_reg.string_lengths <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    usbcer_front u_front
    (
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .req_type         (req_type),
        .request_and_type (request_and_type),
        .setup_value      (setup_value),
        .setup_length     (setup_length),
        .cfg              (cfg_reg),
        .queue_full       (queue_full),
        .push             (push),
        .cmd              (push_cmd)
    );

    usbcer_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .full      (queue_full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_data  (pop_cmd)
    );

    usbcer_back
    #(
        .MAX_PACKET (MAX_PACKET)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (pop_valid),
        .cmd       (pop_cmd),
        .cmd_pop   (pop),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .res       (res)
    );

    assign action            = res.action;
    assign packet_offset     = res.offset;
    assign packet_size       = res.size;
    assign descriptor_select = res.sel;
    assign string_number     = res.str;
    assign data_toggle       = res.toggle;
    assign buffer_odd        = res.odd;
    assign address_write     = res.addr_write;
    assign device_address    = res.addr;
    assign last              = res.last;

endmodule

/* hdl/usbcer_front.sv */
`timescale 1ns / 1ps

module usbcer_front
(
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          req_type,
    input  logic [15:0]         request_and_type,
    input  logic [15:0]         setup_value,
    input  logic [15:0]         setup_length,
    input  usbcer_pkg::cfg_t    cfg,
    input  logic                queue_full,
    output logic                push,
    output usbcer_pkg::cmd_t    cmd
);

    logic [2:0]  str_limit;
    logic        str_hit;
    logic [7:0]  str_len;
    logic [15:0] desc_len;
    logic        keep;

    assign in_stall  = queue_full;
    assign str_limit = (cfg.string_count > 3'(usbcer_pkg::STRING_SLOTS))
                     ? 3'(usbcer_pkg::STRING_SLOTS) : cfg.string_count;
    assign str_hit   = {5'b0, str_limit} > setup_value[7:0];
    assign str_len   = cfg.string_lengths[{setup_value[1:0], 3'b000} +: 8];

    always_comb
    begin
        cmd          = '0;
        cmd.op       = usbcer_pkg::CMD_STALL;
        cmd.addr     = setup_value[6:0];
        cmd.set_addr = (request_and_type == usbcer_pkg::REQ_SET_ADDRESS);
        desc_len     = '0;
        keep         = 1'b1;
        priority case (req_type)
            usbcer_pkg::EV_SETUP:
            begin
                priority if (request_and_type == usbcer_pkg::REQ_SET_ADDRESS
                             || request_and_type == usbcer_pkg::REQ_SET_CONFIG)
                begin
                    cmd.op = usbcer_pkg::CMD_STATUS;
                end
                else if (request_and_type == usbcer_pkg::REQ_GET_DESC_DEV
                         || request_and_type == usbcer_pkg::REQ_GET_DESC_IFACE)
                begin
                    cmd.op = usbcer_pkg::CMD_DATA;
                    priority if (setup_value[15:8] == usbcer_pkg::DESC_TYPE_STRING)
                    begin
                        if (str_hit)
                        begin
                            cmd.sel  = usbcer_pkg::SEL_STRING;
                            cmd.str  = setup_value[1:0];
                            desc_len = {8'b0, str_len};
                        end
                        else
                        begin
                            cmd.op = usbcer_pkg::CMD_STALL;
                        end
                    end
                    else if (setup_value == usbcer_pkg::VAL_DEVICE)
                    begin
                        cmd.sel  = usbcer_pkg::SEL_DEVICE;
                        desc_len = {8'b0, cfg.device_len};
                    end
                    else if (setup_value == usbcer_pkg::VAL_CONFIG)
                    begin
                        cmd.sel  = usbcer_pkg::SEL_CONFIG;
                        desc_len = {6'b0, cfg.config_len};
                    end
                    else if (setup_value == usbcer_pkg::VAL_REPORT)
                    begin
                        cmd.sel  = usbcer_pkg::SEL_REPORT;
                        desc_len = {6'b0, cfg.report_len};
                    end
                    else
                    begin
                        cmd.op = usbcer_pkg::CMD_STALL;
                    end
                end
                else
                begin
                    cmd.op = usbcer_pkg::CMD_STALL;
                end
                // cut the reply to the host's length
                cmd.len = (desc_len > setup_length) ? setup_length : desc_len;
            end
            usbcer_pkg::EV_IN_DONE:
            begin
                cmd.op = usbcer_pkg::CMD_IN;
            end
            usbcer_pkg::EV_BUS_RESET:
            begin
                cmd.op = usbcer_pkg::CMD_BUS_RESET;
            end
            default:
            begin
                // drop OUT, SOF and unused codes
                keep = 1'b0;
            end
        endcase
    end

    assign push = in_valid && !queue_full && keep;

endmodule

/* hdl/usbcer_queue.sv */
`timescale 1ns / 1ps

module usbcer_queue
#(
    parameter int DEPTH = usbcer_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  usbcer_pkg::cmd_t    push_data,
    output logic                full,
    input  logic                pop,
    output logic                pop_valid,
    output usbcer_pkg::cmd_t    pop_data
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    usbcer_pkg::cmd_t  slot_reg [DEPTH];
    logic [PtrW-1:0]   wr_ptr_reg;
    logic [PtrW-1:0]   wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg;
    logic [PtrW-1:0]   rd_ptr_next;
    logic [CntW-1:0]   count_reg;
    logic [CntW-1:0]   count_next;
    logic              do_pop;

    assign full      = (count_reg == CntW'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hdl/usbcer_back.sv */
`timescale 1ns / 1ps

module usbcer_back
#(
    parameter int MAX_PACKET = usbcer_pkg::MAX_PACKET_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  usbcer_pkg::cmd_t     cmd,
    output logic                 cmd_pop,
    input  logic                 out_stall,
    output logic                 out_valid,
    output usbcer_pkg::result_t  res
);

    localparam logic [15:0] MaxPkt = 16'(MAX_PACKET);

    usbcer_pkg::back_state_t state_reg;
    usbcer_pkg::back_state_t state_next;
    logic [15:0]             br_reg;
    logic [15:0]             br_next;
    logic [15:0]             off_reg;
    logic [15:0]             off_next;
    usbcer_pkg::desc_sel_t   sel_reg;
    usbcer_pkg::desc_sel_t   sel_next;
    logic [1:0]              str_reg;
    logic [1:0]              str_next;
    logic                    tog_reg;
    logic                    tog_next;
    logic                    odd_reg;
    logic                    odd_next;
    logic                    setaddr_reg;
    logic                    setaddr_next;
    logic [6:0]              saddr_reg;
    logic [6:0]              saddr_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    usbcer_pkg::result_t     res_reg;
    usbcer_pkg::result_t     res_next;

    logic                    out_free;
    logic                    setup_cmd;
    logic                    data_cmd;
    logic [15:0]             arm_br;
    logic [15:0]             arm_off;
    usbcer_pkg::desc_sel_t   arm_sel;
    logic [1:0]              arm_str;
    logic                    arm_tog;
    logic [15:0]             arm_size;
    logic [15:0]             arm_rem;
    logic [15:0]             arm_next_off;
    usbcer_pkg::result_t     arm_res;

    assign out_free  = !out_valid_reg || !out_stall;
    assign cmd_pop   = (state_reg == usbcer_pkg::BACK_RUN) && cmd_valid && out_free;
    assign data_cmd  = (state_reg == usbcer_pkg::BACK_RUN)
                    && (cmd.op == usbcer_pkg::CMD_DATA);
    assign setup_cmd = data_cmd || ((state_reg == usbcer_pkg::BACK_RUN)
                    && (cmd.op == usbcer_pkg::CMD_STATUS));

    assign arm_br       = setup_cmd ? cmd.len : br_reg;
    assign arm_off      = data_cmd ? 16'd0 : off_reg;
    assign arm_sel      = data_cmd ? cmd.sel : sel_reg;
    assign arm_str      = data_cmd ? cmd.str : str_reg;
    assign arm_tog      = setup_cmd ? 1'b1 : tog_reg;
    assign arm_size     = (arm_br > MaxPkt) ? MaxPkt : arm_br;
    assign arm_rem      = arm_br - arm_size;
    assign arm_next_off = arm_off + arm_size;

    always_comb
    begin
        arm_res        = '0;
        arm_res.action = usbcer_pkg::ACT_ARMED;
        arm_res.offset = arm_off;
        arm_res.size   = arm_size[usbcer_pkg::SIZE_W-1:0];
        arm_res.sel    = arm_sel;
        arm_res.str    = arm_str;
        arm_res.toggle = arm_tog;
        arm_res.odd    = odd_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            usbcer_pkg::BACK_RUN:
            begin
                if (cmd_pop && data_cmd && arm_rem != 16'd0)
                begin
                    state_next = usbcer_pkg::BACK_SECOND;
                end
            end
            usbcer_pkg::BACK_SECOND:
            begin
                if (out_free)
                begin
                    state_next = usbcer_pkg::BACK_RUN;
                end
            end
            default:
            begin
                state_next = usbcer_pkg::BACK_RUN;
            end
        endcase
    end

    always_comb
    begin
        br_next        = br_reg;
        off_next       = off_reg;
        sel_next       = sel_reg;
        str_next       = str_reg;
        tog_next       = tog_reg;
        odd_next       = odd_reg;
        setaddr_next   = setaddr_reg;
        saddr_next     = saddr_reg;
        res_next       = res_reg;
        out_valid_next = out_free ? 1'b0 : out_valid_reg;
        unique case (state_reg)
            usbcer_pkg::BACK_SECOND:
            begin
                if (out_free)
                begin
                    res_next       = arm_res;
                    res_next.last  = 1'b1;
                    out_valid_next = 1'b1;
                    br_next        = arm_rem;
                    off_next       = arm_next_off;
                    tog_next       = !arm_tog;
                    odd_next       = !odd_reg;
                end
            end
            usbcer_pkg::BACK_RUN:
            begin
                if (cmd_pop)
                begin
                    unique case (cmd.op)
                        usbcer_pkg::CMD_STALL:
                        begin
                            res_next        = '0;
                            res_next.action = usbcer_pkg::ACT_STALL;
                            res_next.last   = 1'b1;
                            out_valid_next  = 1'b1;
                            tog_next        = 1'b1;
                            setaddr_next    = 1'b0;
                            saddr_next      = cmd.addr;
                        end
                        usbcer_pkg::CMD_STATUS, usbcer_pkg::CMD_DATA:
                        begin
                            res_next       = arm_res;
                            res_next.last  = (arm_rem == 16'd0);
                            out_valid_next = 1'b1;
                            br_next        = arm_rem;
                            off_next       = arm_next_off;
                            sel_next       = arm_sel;
                            str_next       = arm_str;
                            tog_next       = !arm_tog;
                            odd_next       = !odd_reg;
                            setaddr_next   = cmd.set_addr;
                            saddr_next     = cmd.addr;
                        end
                        usbcer_pkg::CMD_IN:
                        begin
                            if (br_reg != 16'd0)
                            begin
                                res_next            = arm_res;
                                res_next.addr_write = setaddr_reg;
                                res_next.addr       = setaddr_reg ? saddr_reg : 7'd0;
                                res_next.last       = 1'b1;
                                out_valid_next      = 1'b1;
                                br_next             = arm_rem;
                                off_next            = arm_next_off;
                                tog_next            = !arm_tog;
                                odd_next            = !odd_reg;
                            end
                            else if (setaddr_reg)
                            begin
                                res_next            = '0;
                                res_next.action     = usbcer_pkg::ACT_NONE;
                                res_next.addr_write = 1'b1;
                                res_next.addr       = saddr_reg;
                                res_next.last       = 1'b1;
                                out_valid_next      = 1'b1;
                            end
                        end
                        usbcer_pkg::CMD_BUS_RESET:
                        begin
                            res_next            = '0;
                            res_next.action     = usbcer_pkg::ACT_NONE;
                            res_next.addr_write = 1'b1;
                            res_next.last       = 1'b1;
                            out_valid_next      = 1'b1;
                            br_next             = '0;
                            off_next            = '0;
                            sel_next            = usbcer_pkg::SEL_DEVICE;
                            str_next            = '0;
                            tog_next            = 1'b0;
                            odd_next            = 1'b0;
                            setaddr_next        = 1'b0;
                            saddr_next          = '0;
                        end
                        default:
                        begin
                            out_valid_next = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= usbcer_pkg::BACK_RUN;
            br_reg        <= '0;
            off_reg       <= '0;
            sel_reg       <= usbcer_pkg::SEL_DEVICE;
            str_reg       <= '0;
            tog_reg       <= 1'b0;
            odd_reg       <= 1'b0;
            setaddr_reg   <= 1'b0;
            saddr_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            br_reg        <= br_next;
            off_reg       <= off_next;
            sel_reg       <= sel_next;
            str_reg       <= str_next;
            tog_reg       <= tog_next;
            odd_reg       <= odd_next;
            setaddr_reg   <= setaddr_next;
            saddr_reg     <= saddr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

/* hdl/usbcer_checker.sv */
`timescale 1ns / 1ps
`include "usb_control_endpoint_responder_defines.svh"

module usbcer_checker
#(
    parameter int MAX_PACKET = usbcer_pkg::MAX_PACKET_DEFAULT
)
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] action,
    input logic [6:0] packet_size,
    input logic       data_toggle,
    input logic       address_write,
    input logic       last
);

    logic is_stall;
    logic is_none;
    logic is_packet;
    logic first_of_two;
    logic waiting;

    assign is_stall     = out_valid && (action == usbcer_pkg::ACT_STALL);
    assign is_none      = out_valid && (action == usbcer_pkg::ACT_NONE);
    assign is_packet    = out_valid && (action == usbcer_pkg::ACT_ARMED);
    assign first_of_two = out_valid && !out_stall && !last;
    assign waiting      = out_valid && out_stall;

    `USBCER_ASSERT_NOW(a_stall_bare, is_stall, packet_size == 7'd0 && !address_write && last)
    `USBCER_ASSERT_NOW(a_none_is_address, is_none, address_write && packet_size == 7'd0 && last)
    `USBCER_ASSERT_NOW(a_size_bound, out_valid, packet_size <= 7'(MAX_PACKET))
    `USBCER_ASSERT_NEXT(a_second, first_of_two, is_packet && data_toggle != $past(data_toggle))
    `USBCER_ASSERT_NEXT(a_hold, waiting, out_valid && $stable(packet_size) && $stable(last))

endmodule

bind usb_control_endpoint_responder usbcer_checker
#(
    .MAX_PACKET (MAX_PACKET)
)
u_usbcer_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .action        (action),
    .packet_size   (packet_size),
    .data_toggle   (data_toggle),
    .address_write (address_write),
    .last          (last)
);
